FILE: rtl/icr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icr_pkg;

    // field and datapath widths
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 22;
    localparam int SEED_W   = 23;
    localparam int DEN_W    = 2 * SEED_W;
    localparam int QUOT_W   = 32;
    localparam int EXT_W    = DEN_W + QUOT_W;
    localparam int LEN_W    = 7;
    localparam int SHIFT_W  = 5;
    localparam int SROOT_W  = 3;
    localparam int TAB_W    = 8;
    localparam int IDX_W    = 6;
    localparam int GROUP_W  = 16;
    localparam int GROUPS   = RAD_W / GROUP_W;
    localparam int GPOS_W   = 4;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = QUOT_W;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // arithmetic constants of the seed and the newton step
    localparam int SMALL_LEN    = 7;
    localparam int SMALL_BIAS   = 35;
    localparam int SEED_BIAS    = 10;
    localparam int SCALE_NUM    = 84;
    localparam int SCALE_SHIFT  = 8;
    localparam int NORM_SHIFT   = 6;
    localparam int NEWTON_MUL   = 341;
    localparam int NEWTON_SHIFT = 10;

    // seed table, indexed by the top bits of the normalized radicand
    localparam logic [TAB_W-1:0] SEED_TAB [0:63] = '{
        8'd0,   8'd54,  8'd54,  8'd54,  8'd118, 8'd118, 8'd118, 8'd118,
        8'd123, 8'd129, 8'd134, 8'd138, 8'd143, 8'd147, 8'd151, 8'd156,
        8'd157, 8'd161, 8'd164, 8'd168, 8'd170, 8'd173, 8'd176, 8'd179,
        8'd181, 8'd185, 8'd187, 8'd190, 8'd192, 8'd194, 8'd197, 8'd199,
        8'd200, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd222, 8'd224, 8'd225, 8'd227, 8'd229,
        8'd231, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242,
        8'd244, 8'd245, 8'd246, 8'd248, 8'd250, 8'd251, 8'd252, 8'd254
    };

    // classified item handed from front to back
    typedef struct packed {
        logic [RAD_W-1:0]   radicand;
        logic [SEED_W-1:0]  seed;
        logic               tab_path;
        logic [SROOT_W-1:0] small_root;
    } icr_job_t;

    // payload of one divider stage
    typedef struct packed {
        logic [RAD_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [SEED_W-1:0]  seed;
        logic [QUOT_W-1:0]  quot;
        logic               den_zero;
        logic               tab_path;
        logic [SROOT_W-1:0] small_root;
    } icr_div_t;

endpackage

`default_nettype wire

FILE: rtl/integer_cube_root_core.sv
// integer cube root: table seed plus one newton step on a 64-bit radicand
// (table alone for short radicands); input to m_valid: 3 front stages, queue,
// divisor multiply, 32 divider stages, output register; throughput: one item
// per cycle if m_ready is high, set by the fully pipelined restoring divider
// reset: synchronous active-low aresetn empties all stages and the queue
`timescale 1ns / 1ps
`default_nettype none

module integer_cube_root_core #(
    parameter int QUEUE_DEPTH = icr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_radicand,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [21:0]      m_root
);
    import icr_pkg::*;

    logic     front_valid, front_ready;
    icr_job_t front_job;
    logic     back_valid, back_ready;
    icr_job_t back_job;

    // classify and seed
    icr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_radicand (s_radicand),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job         (front_job)
    );

    // decoupling queue
    icr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_job   (front_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_job   (back_job)
    );

    // divide and refine
    icr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_root  (m_root)
    );

endmodule

`default_nettype wire

FILE: rtl/icr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module icr_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [63:0]              in_radicand,
    output logic                          job_valid,
    input  wire logic                     job_ready,
    output icr_pkg::icr_job_t             job
);
    import icr_pkg::*;

    // stage valids
    logic v1_reg, v2_reg, v3_reg;
    logic adv;

    // stage 1: group scan
    logic [RAD_W-1:0]  a1_reg;
    logic [GROUPS-1:0] nz1_reg, nz1_next;
    logic [GPOS_W-1:0] pos1_reg [GROUPS];
    logic [GPOS_W-1:0] pos1_next [GROUPS];

    // stage 2: bit length, shift and small path
    logic [RAD_W-1:0]   a2_reg;
    logic [SHIFT_W-1:0] sh2_reg, sh2_next;
    logic               small2_reg, small2_next;
    logic [SROOT_W-1:0] sroot2_reg, sroot2_next;
    logic [LEN_W-1:0]   len;
    logic [12:0]        len_scaled;
    logic [TAB_W:0]     small_sum;

    // stage 3: table seed
    icr_job_t           job_reg, job_next;
    logic [LEN_W-1:0]   shamt;
    logic [RAD_W-1:0]   shifted;
    logic [TAB_W:0]     seed_base;
    logic [39:0]        seed_wide;

    // whole front moves together
    assign adv      = !v3_reg || job_ready;
    assign in_ready = adv;

    // highest set bit inside each 16-bit group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            nz1_next[g]  = |in_radicand[g*GROUP_W +: GROUP_W];
            pos1_next[g] = '0;
            for (int j = 0; j < GROUP_W; j++) begin
                if (in_radicand[g*GROUP_W + j]) begin
                    pos1_next[g] = GPOS_W'(j);
                end
            end
        end
    end

    // combine groups into the bit length
    always_comb begin
        len = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (nz1_reg[g]) begin
                len = LEN_W'(g * GROUP_W) + LEN_W'(pos1_reg[g]) + LEN_W'(1);
            end
        end
        len_scaled  = 13'(len) * 13'(SCALE_NUM);
        sh2_next    = len_scaled[SCALE_SHIFT +: SHIFT_W] - SHIFT_W'(1);
        small2_next = len < LEN_W'(SMALL_LEN);
        small_sum   = {1'b0, SEED_TAB[a1_reg[IDX_W-1:0]]} + (TAB_W+1)'(SMALL_BIAS);
        sroot2_next = small_sum[NORM_SHIFT +: SROOT_W];
    end

    // normalize, look up and scale the seed
    always_comb begin
        shamt     = {2'b00, sh2_reg} + {1'b0, sh2_reg, 1'b0};
        shifted   = a2_reg >> shamt;
        seed_base = {1'b0, SEED_TAB[shifted[IDX_W-1:0]]} + (TAB_W+1)'(SEED_BIAS);
        seed_wide = 40'(seed_base) << sh2_reg;
        job_next.radicand   = a2_reg;
        job_next.seed       = seed_wide[NORM_SHIFT +: SEED_W];
        job_next.tab_path   = small2_reg;
        job_next.small_root = sroot2_reg;
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg     <= in_radicand;
            nz1_reg    <= nz1_next;
            pos1_reg   <= pos1_next;
            a2_reg     <= a1_reg;
            sh2_reg    <= sh2_next;
            small2_reg <= small2_next;
            sroot2_reg <= sroot2_next;
            job_reg    <= job_next;
        end
    end

    assign job_valid = v3_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

FILE: rtl/icr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module icr_fifo #(
    parameter int DEPTH = icr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_valid,
    output logic                          wr_ready,
    input  wire icr_pkg::icr_job_t        wr_job,
    output logic                          rd_valid,
    input  wire logic                     rd_ready,
    output icr_pkg::icr_job_t             rd_job
);
    import icr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    icr_job_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push, pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/icr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module icr_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     job_valid,
    output logic                          job_ready,
    input  wire icr_pkg::icr_job_t        job,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [21:0]                   out_root
);
    import icr_pkg::*;

    logic                   adv;
    logic [DIV_STEPS:0]     valid_reg;
    icr_div_t               stage_reg [0:DIV_STEPS];
    icr_div_t               stage0_next;
    logic                   out_valid_reg;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [QUOT_W-1:0]      quot_used;
    logic [QUOT_W-1:0]      newton_sum;
    logic [41:0]            newton_prod;

    // whole back moves together when the output register can take a result
    assign adv       = !out_valid_reg || out_ready;
    assign job_ready = adv;

    // divisor x*(x-1) and divider setup
    always_comb begin
        stage0_next.rem        = job.radicand;
        stage0_next.den        = DEN_W'(job.seed) * DEN_W'(job.seed - 1'b1);
        stage0_next.seed       = job.seed;
        stage0_next.quot       = '0;
        stage0_next.den_zero   = job.seed < SEED_W'(2);
        stage0_next.tab_path   = job.tab_path;
        stage0_next.small_root = job.small_root;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg[0] <= stage0_next;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        localparam int BIT = DIV_STEPS - k;
        logic [EXT_W-1:0] trial;
        logic [EXT_W-1:0] rem_ext;
        logic [EXT_W-1:0] diff;
        logic             take;
        icr_div_t         div_next;

        always_comb begin
            trial    = EXT_W'(stage_reg[k-1].den) << BIT;
            rem_ext  = EXT_W'(stage_reg[k-1].rem);
            diff     = rem_ext - trial;
            take     = rem_ext >= trial;
            div_next = stage_reg[k-1];
            div_next.rem  = take ? diff[RAD_W-1:0] : stage_reg[k-1].rem;
            div_next.quot = {stage_reg[k-1].quot[QUOT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stage_reg[k] <= div_next;
            end
        end
    end

    // newton step: ((2x + q) * 341) >> 10 in 32-bit arithmetic
    always_comb begin
        quot_used   = stage_reg[DIV_STEPS].den_zero ? '0 : stage_reg[DIV_STEPS].quot;
        newton_sum  = {QUOT_W'(stage_reg[DIV_STEPS].seed)} + {QUOT_W'(stage_reg[DIV_STEPS].seed)}
                      + quot_used;
        newton_prod = 42'(newton_sum) * 42'(NEWTON_MUL);
        root_next   = stage_reg[DIV_STEPS].tab_path
                      ? ROOT_W'(stage_reg[DIV_STEPS].small_root)
                      : newton_prod[NEWTON_SHIFT +: ROOT_W];
    end

    // stage valids and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[DIV_STEPS-1:0], job_valid};
            out_valid_reg <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            root_reg <= root_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_root  = root_reg;

endmodule

`default_nettype wire

FILE: rtl/icr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module icr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [21:0] m_root
);

    // items accepted but not yet delivered
    logic [7:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 8'(s_valid && s_ready) - 8'(m_valid && m_ready);
        end
    end

    // reset leaves no result on the output
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // an empty pipeline takes input right after reset
    a_reset_ready: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> s_ready)
        else $error("input not ready after reset");

    // no result without an accepted item behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 8'd0)
        else $error("result without pending item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root))
        else $error("stalled result changed");

endmodule

bind integer_cube_root_core icr_checker u_icr_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_ITEMS = 900;
    localparam int BURST_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 300;

    // tracks expected roots in transfer order and checks what comes out
    class cube_root_board;
        logic [21:0] expected_roots[$];
        int          radicands_seen;
        int          roots_checked;
        int          mismatches;

        // table seed plus one newton step, with 32-bit wraparound as in the block
        function automatic logic [21:0] predict_root(logic [63:0] a);
            bit [31:0] len;
            bit [31:0] sh;
            bit [31:0] idx;
            bit [31:0] x;
            bit [31:0] xm1;
            bit [31:0] q;
            bit [63:0] den;
            bit [63:0] quo_full;
            len = 0;
            for (int i = 0; i < 64; i++)
                if (a[i]) len = i + 1;
            // short radicands come straight from the table
            if (len < icr_pkg::SMALL_LEN) begin
                x = (32'(icr_pkg::SEED_TAB[a[5:0]]) + 32'(icr_pkg::SMALL_BIAS))
                    >> icr_pkg::NORM_SHIFT;
                return x[21:0];
            end
            // normalize and seed
            sh  = ((len * 32'(icr_pkg::SCALE_NUM)) >> icr_pkg::SCALE_SHIFT) - 32'd1;
            idx = 32'(a >> (sh * 32'd3)) & 32'd63;
            x   = ((32'(icr_pkg::SEED_TAB[idx]) + 32'(icr_pkg::SEED_BIAS)) << sh)
                  >> icr_pkg::NORM_SHIFT;
            // newton step
            xm1 = x - 32'd1;
            den = {32'd0, x} * {32'd0, xm1};
            quo_full = (den != 64'd0) ? a / den : 64'd0;
            q   = quo_full[31:0];
            x   = (x << 1) + q;
            x   = (x * 32'(icr_pkg::NEWTON_MUL)) >> icr_pkg::NEWTON_SHIFT;
            return x[21:0];
        endfunction

        function void note_radicand(logic [63:0] v);
            expected_roots.push_back(predict_root(v));
            radicands_seen++;
        endfunction

        function void check_root(logic [21:0] got);
            logic [21:0] want;
            roots_checked++;
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("root %0d arrived with nothing pending", got);
                return;
            end
            want = expected_roots.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("root mismatch at result %0d: expected %0d, got %0d",
                             roots_checked, want, got);
            end
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [63:0] s_radicand = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [21:0] m_root;

    cube_root_board board = new();
    bit  steady   = 1'b0;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;
    int  small_count = 0;

    integer_cube_root_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_radicand (s_radicand),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_root     (m_root)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    // radicand with a random bit length, now and then fully random
    function automatic logic [63:0] random_radicand();
        logic [63:0] v;
        int unsigned len;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 2) return v;
        len = $urandom_range(0, 64);
        if (len == 0) return '0;
        if (len < 64) v = v & ((64'd1 << len) - 64'd1);
        v[len-1] = 1'b1;
        return v;
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 2) != 0) return 0;
        return pick_gap();
    endfunction

    // offer one radicand after an optional idle gap and wait for its transfer
    task automatic send_radicand(input logic [63:0] v, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_radicand <= v;
        if (v < 64'd64) small_count++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_all_roots();
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // input transfers feed the predictor, output transfers get checked
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_radicand(s_radicand);
        if (aresetn && m_valid && m_ready) board.check_root(m_root);
    end

    // receiver back-pressure, plus one long hold on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d roots pending",
                     cycle_count, board.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [63:0] directed [$];
        directed = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd7, 64'd8, 64'd27, 64'd63,
            64'd64, 64'd65, 64'd127, 64'd128, 64'd1000, 64'd1000000,
            64'h0000_0001_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'd999_999_999_999_999_999
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        foreach (directed[i]) send_radicand(directed[i], sender_gap());

        // long output hold while the sender keeps pushing
        hold_req = 1'b1;
        steady   = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++) send_radicand(random_radicand(), 0);
        steady = 1'b0;

        // sender pauses until every root is back
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_all_roots();

        // random radicands, with a stretch without idling in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 300 && i < 450);
            send_radicand(random_radicand(), sender_gap());
        end
        steady = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        wait_all_roots();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d radicands (%0d in the small table range), %0d roots checked",
                 board.radicands_seen, small_count, board.roots_checked);
        $display("included full output hold, sender pause and back-to-back stretches");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d roots left over",
                     board.mismatches, board.pending());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/icr_pkg.sv
rtl/icr_front.sv
rtl/icr_fifo.sv
rtl/icr_back.sv
rtl/integer_cube_root_core.sv
rtl/icr_checker.sv
tb/sv/tb_top.sv
